FILE: rtl/core/rmt_pkg.sv
package rmt_pkg;

  localparam int unsigned DEF_CAPACITY = 16;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned TAG_W   = 32;
  localparam int unsigned TOTAL_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_LIST   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_EMIT
  } state_t;

  // One stored range as it sits in the entry memory.
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  length;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Outcome of comparing the probe range against one stored range.
  typedef struct packed {
    logic overlap;
    logic holds;
    logic base_le;
  } cmp_t;

endpackage

FILE: rtl/core/rmt_if.sv
interface rmt_cmd_if;
  import rmt_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  length;
  logic [TAG_W-1:0]  tag;

  modport source (output valid, op, address, length, tag, input ready);
  modport sink (input valid, op, address, length, tag, output ready);
endinterface

interface rmt_rsp_if;
  import rmt_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ADDR_W-1:0]  entry_base;
  logic [LEN_W-1:0]   entry_length;
  logic [TAG_W-1:0]   entry_tag;
  logic [TOTAL_W-1:0] entry_total;
  logic               last;

  modport source (output valid, status, entry_base, entry_length, entry_tag,
                  entry_total, last, input ready);
  modport sink (input valid, status, entry_base, entry_length, entry_tag,
                entry_total, last, output ready);
endinterface

FILE: rtl/core/rmt_ram.sv
module rmt_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/rmt_cmp.sv
module rmt_cmp (
  input  rmt_pkg::entry_t probe,
  input  rmt_pkg::entry_t stored,
  output rmt_pkg::cmp_t   result
);
  import rmt_pkg::*;

  logic [ADDR_W-1:0] probe_end;
  logic [ADDR_W-1:0] stored_end;

  // Range ends wrap modulo 2^64, exactly as the sums are defined.
  assign probe_end  = probe.base + ADDR_W'(probe.length);
  assign stored_end = stored.base + ADDR_W'(stored.length);

  assign result.overlap = (stored.base < probe_end) && (probe.base < stored_end);
  assign result.holds   = (probe.base >= stored.base) && (probe.base < stored_end);
  assign result.base_le = (stored.base <= probe.base);

endmodule

FILE: rtl/core/range_map_table.sv
// Range map table: holds up to CAPACITY non-overlapping half-open ranges
// [base, base+length), each with a tag, kept in ascending base order.
// The cmd channel carries one operation per transaction: insert a range,
// look up the range that holds an address, or list every stored range.
// The rsp channel returns one transaction per insert and lookup, and one
// per stored entry for a list (last marks the final one); an empty list or
// an unused op code returns a single not-found transaction.
// Each operation walks the entry memory through its single registered read
// port: a stored entry is addressed, then compared. Insert scans every entry
// for overlap (stopping at the first), reads and writes back each entry that
// moves up to open a slot, then writes the slot and hands over the result.
// Lookup visits entries up to the first match. List addresses, compares and
// hands over each entry before reading the next, pausing while rsp stalls.
// cmd.ready is high only while no operation is in progress; a result that
// is waiting in the rsp register does not block the next operation from
// being accepted, but a further result waits until the register is free.
// When the receiver stalls, the walk pauses in place and nothing is lost.
// Synchronous reset empties the table (the count goes to zero) and drops
// any pending response; the entry memory itself is not cleared.
module range_map_table #(
  parameter int unsigned CAPACITY = rmt_pkg::DEF_CAPACITY
) (
  input logic         clk,
  input logic         rst,
  rmt_cmd_if.sink     cmd,
  rmt_rsp_if.source   rsp
);
  import rmt_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  state_t state, state_next;

  // Number of stored entries; only entries below it are ever compared or moved.
  logic [CNT_W-1:0] count;
  // Walk index and insertion slot for the operation in progress.
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] idx_dec;
  logic [CNT_W-1:0] pos_upd;
  logic             scan_last;
  logic             table_full;

  logic [1:0] op_q;
  entry_t     probe;

  // Result being assembled before it moves into the rsp register.
  logic [1:0] res_status;
  entry_t     res_entry;
  logic       res_last;

  // rsp output register.
  logic               out_valid;
  logic [1:0]         out_status;
  entry_t             out_entry;
  logic [TOTAL_W-1:0] out_total;
  logic               out_last;

  logic             cmd_fire;
  logic             emit_go;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;

  cmp_t             cmp;

  rmt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The one compare unit, shared by the overlap scan, the slot search and
  // the lookup scan; it always sees the entry just read.
  rmt_cmp u_cmp (
    .probe  (probe),
    .stored (ram_rdata),
    .result (cmp)
  );

  assign idx_inc    = idx + CNT_W'(1);
  assign idx_dec    = idx - CNT_W'(1);
  assign scan_last  = (idx_inc == count);
  assign table_full = (count == CNT_W'(CAPACITY));
  // Entries are sorted, so those with base not above the new base form a
  // prefix; a new entry goes after equal bases.
  assign pos_upd    = cmp.base_le ? idx_inc : pos;

  assign cmd_fire = cmd.valid && cmd.ready;
  assign emit_go  = (state == S_EMIT) && (!out_valid || rsp.ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          if ((cmd.op == OP_INSERT || cmd.op == OP_LOOKUP || cmd.op == OP_LIST)
              && count != '0) begin
            state_next = S_RD;
          end else if (cmd.op == OP_INSERT) begin
            state_next = S_PUT;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_RD: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        unique case (op_q)
          OP_INSERT: begin
            if (cmp.overlap) begin
              state_next = S_EMIT;
            end else if (scan_last) begin
              if (table_full) begin
                state_next = S_EMIT;
              end else if (pos_upd == count) begin
                state_next = S_PUT;
              end else begin
                state_next = S_SHIFT_RD;
              end
            end else begin
              state_next = S_RD;
            end
          end
          OP_LOOKUP: begin
            state_next = (cmp.holds || scan_last) ? S_EMIT : S_RD;
          end
          default: begin
            state_next = S_EMIT;
          end
        endcase
      end
      S_SHIFT_RD: begin
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        state_next = (idx_dec == pos) ? S_PUT : S_SHIFT_RD;
      end
      S_PUT: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          state_next = (op_q == OP_LIST && !res_last) ? S_RD : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Memory controls and handshake.
  always_comb begin
    cmd.ready = (state == S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = idx[IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx[IDX_W-1:0];
    unique case (state)
      S_SHIFT_RD: begin
        ram_raddr = idx_dec[IDX_W-1:0];
      end
      S_SHIFT_WR: begin
        ram_we = 1'b1;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos[IDX_W-1:0];
        ram_wdata = probe;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_PUT) begin
        count <= count + CNT_W'(1);
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Operation and result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          op_q         <= cmd.op;
          probe.base   <= cmd.address;
          probe.length <= cmd.length;
          probe.tag    <= cmd.tag;
          idx          <= '0;
          pos          <= '0;
          res_status   <= ST_NONE;
          res_entry    <= '0;
          res_last     <= 1'b1;
        end
      end
      S_CHK: begin
        unique case (op_q)
          OP_INSERT: begin
            pos <= pos_upd;
            // After the scan, the shift starts from the first free slot.
            idx <= scan_last ? count : idx_inc;
            if (cmp.overlap) begin
              res_status <= ST_OVERLAP;
            end else if (scan_last && table_full) begin
              res_status <= ST_FULL;
            end
          end
          OP_LOOKUP: begin
            idx <= idx_inc;
            if (cmp.holds) begin
              res_status <= ST_OK;
              res_entry  <= ram_rdata;
            end
          end
          default: begin
            res_status <= ST_OK;
            res_entry  <= ram_rdata;
            res_last   <= scan_last;
          end
        endcase
      end
      S_SHIFT_WR: begin
        idx <= idx_dec;
      end
      S_PUT: begin
        res_status <= ST_OK;
      end
      S_EMIT: begin
        if (emit_go && op_q == OP_LIST) begin
          idx <= idx_inc;
        end
      end
      default: begin
      end
    endcase

    if (emit_go) begin
      out_status <= res_status;
      out_entry  <= res_entry;
      out_total  <= TOTAL_W'(count);
      out_last   <= res_last;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.entry_base   = out_entry.base;
  assign rsp.entry_length = out_entry.length;
  assign rsp.entry_tag    = out_entry.tag;
  assign rsp.entry_total  = out_total;
  assign rsp.last         = out_last;

  // The table never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Only the slot write of an accepted insert changes the count.
  a_count_only_put: assert property (@(posedge clk) disable iff (rst)
    state != S_PUT |=> count == $past(count))
    else $error("entry count changed outside an insert");

  // The shift stops at the insertion slot and never passes it.
  a_shift_above_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT_RD |-> idx > pos)
    else $error("shift walked past the insertion slot");

  // Only a list produces more than one response, and each carries an entry.
  a_multi_is_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.last |-> rsp.status == ST_OK)
    else $error("non-final response without an entry");

endmodule
